// File: rtl/core/cnsl_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package cnsl_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = ROWS * COLUMNS;

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int IDX_W = 11;
	localparam int CELL_W = 16;

	localparam int DIV_SHIFT = IDX_W + 8;
	localparam int DIV_RECIP = (2 ** DIV_SHIFT) / COLUMNS;
	localparam int PROD_W = IDX_W + DIV_SHIFT;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam int PADDR_W = 3;
	localparam logic REG_TEXT_ATTR = 1'b0;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] ATTR_RESET = 8'h07;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_GLYPH,
		CMD_NEWLINE,
		CMD_BACKSPACE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       glyph;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             in_range;
	} cmd_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_BSWR,
		S_RDWAIT,
		S_BLANK
	} back_state_t;

	typedef struct packed {
		logic             mode;
		logic [7:0]       char_code;
		logic [IDX_W-1:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] cursor_position;
		logic [7:0]       read_glyph;
		logic [7:0]       read_attribute;
		logic             did_scroll;
	} out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/cnsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cnsl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/cnsl_front.sv
// Front end: takes items, classifies them and splits read addresses into row and column.
`default_nettype none

module cnsl_front import cnsl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	input  wire logic     q_full,
	output logic          push,
	output cmd_t          cmd,
	output logic          front_busy
);

	localparam int REM_W = 16;

	logic             v_s1;
	cmd_kind_t        kind_s1;
	logic [7:0]       glyph_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [IDX_W-1:0] q0;
	logic [REM_W-1:0] qc;
	logic [REM_W-1:0] rem;

	function automatic cmd_kind_t classify(input in_item_t it);
		cmd_kind_t k;
		if (it.mode) begin
			k = CMD_READ;
		end else if (it.char_code == CH_NEWLINE) begin
			k = CMD_NEWLINE;
		end else if (it.char_code == CH_BACKSPACE) begin
			k = CMD_BACKSPACE;
		end else begin
			k = CMD_GLYPH;
		end
		return k;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= classify(item);
			glyph_s1 <= item.char_code;
			idx_s1 <= item.cell_index;
			prod_s1 <= PROD_W'(item.cell_index) * PROD_W'(DIV_RECIP);
		end
	end

	always_comb begin
		q0 = prod_s1[DIV_SHIFT +: IDX_W];
		qc = REM_W'(q0) * REM_W'(COLUMNS);
		rem = REM_W'(idx_s1) - qc;
		cmd.kind = kind_s1;
		cmd.glyph = glyph_s1;
		cmd.in_range = 32'(idx_s1) < 32'(CELLS);
		if (rem >= REM_W'(COLUMNS)) begin
			cmd.row = ROW_W'(q0 + IDX_W'(1));
			cmd.col = COL_W'(rem - REM_W'(COLUMNS));
		end else begin
			cmd.row = ROW_W'(q0);
			cmd.col = COL_W'(rem);
		end
	end

	assign push = v_s1 && !q_full;
	assign front_busy = v_s1;

endmodule

`default_nettype wire

// File: rtl/core/cnsl_queue.sv
// Short command queue between front end and back end.
`default_nettype none

module cnsl_queue import cnsl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      full,
	output logic      empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head = entry_q[rd_ptr_q];
	assign full = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;

endmodule

`default_nettype wire

// File: rtl/core/cnsl_back.sv
// Back end: cursor, screen store, scroll blanking, clearing pass and result register.
`default_nettype none

module cnsl_back import cnsl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] text_attr,
	input  wire cmd_t       q_head,
	input  wire logic       q_empty,
	output logic            pop,
	output logic            clearing,
	output logic            done,
	output out_item_t       result
);

	back_state_t      state_q, state_d;
	logic [ROW_W-1:0] cur_row_q, cur_row_d;
	logic [COL_W-1:0] cur_col_q, cur_col_d;
	logic [ROW_W-1:0] top_q, top_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [ADDR_W-1:0] base_q, base_d;
	cmd_t             cmd_q, cmd_d;
	logic             pend_q, pend_d;
	logic [7:0]       pend_glyph_q, pend_glyph_d;
	logic [7:0]       pend_attr_q, pend_attr_d;
	logic             pend_scroll_q, pend_scroll_d;
	logic             done_q;
	out_item_t        result_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr;
	logic [CELL_W-1:0] rdata;
	logic [ADDR_W-1:0] cur_addr;
	logic              last_col;
	logic              last_row;

	function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] top);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, top};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			sum = sum - (ROW_W+1)'(ROWS);
		end
		return ADDR_W'(int'(sum) * COLUMNS + int'(col));
	endfunction

	cnsl_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cur_addr = phys_addr(cur_row_q, cur_col_q, top_q);
	assign last_col = cur_col_q == COL_W'(COLUMNS - 1);
	assign last_row = cur_row_q == ROW_W'(ROWS - 1);

	always_comb begin
		state_d = state_q;
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		top_d = top_q;
		cnt_d = cnt_q;
		base_d = base_q;
		cmd_d = cmd_q;
		pend_d = 1'b0;
		pend_glyph_d = pend_glyph_q;
		pend_attr_d = pend_attr_q;
		pend_scroll_d = pend_scroll_q;
		pop = 1'b0;
		we = 1'b0;
		waddr = cur_addr;
		wdata = {cmd_q.glyph, text_attr};
		raddr = phys_addr(cmd_q.row, cmd_q.col, top_q);

		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = cnt_q;
				wdata = {CH_SPACE, ATTR_RESET};
				cnt_d = cnt_q + ADDR_W'(1);
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					cnt_d = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					cmd_d = q_head;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				pend_glyph_d = '0;
				pend_attr_d = '0;
				pend_scroll_d = 1'b0;
				case (cmd_q.kind)
					CMD_READ: begin
						if (cmd_q.in_range) begin
							state_d = S_RDWAIT;
						end else begin
							pend_d = 1'b1;
							state_d = S_IDLE;
						end
					end
					CMD_GLYPH, CMD_NEWLINE: begin
						we = cmd_q.kind == CMD_GLYPH;
						if (cmd_q.kind == CMD_GLYPH && !last_col) begin
							cur_col_d = cur_col_q + COL_W'(1);
							pend_d = 1'b1;
							state_d = S_IDLE;
						end else if (!last_row) begin
							cur_col_d = '0;
							cur_row_d = cur_row_q + ROW_W'(1);
							pend_d = 1'b1;
							state_d = S_IDLE;
						end else begin
							cur_col_d = '0;
							top_d = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
							base_d = ADDR_W'(int'(top_q) * COLUMNS);
							cnt_d = '0;
							state_d = S_BLANK;
						end
					end
					CMD_BACKSPACE: begin
						if (cur_row_q == '0 && cur_col_q == '0) begin
							pend_d = 1'b1;
							state_d = S_IDLE;
						end else begin
							if (cur_col_q == '0) begin
								cur_col_d = COL_W'(COLUMNS - 1);
								cur_row_d = cur_row_q - ROW_W'(1);
							end else begin
								cur_col_d = cur_col_q - COL_W'(1);
							end
							state_d = S_BSWR;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_BSWR: begin
				we = 1'b1;
				wdata = {CH_SPACE, text_attr};
				pend_d = 1'b1;
				state_d = S_IDLE;
			end
			S_RDWAIT: begin
				pend_glyph_d = rdata[CELL_W-1 -: 8];
				pend_attr_d = rdata[7:0];
				pend_d = 1'b1;
				state_d = S_IDLE;
			end
			S_BLANK: begin
				we = 1'b1;
				waddr = base_q + cnt_q;
				wdata = {CH_SPACE, text_attr};
				cnt_d = cnt_q + ADDR_W'(1);
				if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
					cnt_d = '0;
					pend_scroll_d = 1'b1;
					pend_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_row_q <= '0;
			cur_col_q <= '0;
			top_q <= '0;
			cnt_q <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			top_q <= top_d;
			cnt_q <= cnt_d;
			pend_q <= pend_d;
			done_q <= pend_q;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		cmd_q <= cmd_d;
		pend_glyph_q <= pend_glyph_d;
		pend_attr_q <= pend_attr_d;
		pend_scroll_q <= pend_scroll_d;
		if (pend_q) begin
			result_q.cursor_position <= IDX_W'(int'(cur_row_q) * COLUMNS + int'(cur_col_q));
			result_q.read_glyph <= pend_glyph_q;
			result_q.read_attribute <= pend_attr_q;
			result_q.did_scroll <= pend_scroll_q;
		end
	end

	assign clearing = state_q == S_CLEAR;
	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer_top.sv
// Top level of the text console writer: configuration port and block wiring.
`default_nettype none

// Text console of 25 rows by 80 cells. After reset the block clears the screen store
// to spaces, one cell a cycle, and holds busy high while it does so. An item is taken
// when start is high and busy low. Busy then stays high while the item is classified,
// and for longer while the queue to the back end is full. Each item gives one result,
// marked by done for one cycle; the receiver cannot hold results off. Each item passes
// the front-end register and the queue, is popped in the back end's idle state and run
// in its execute state, then passes the pending and done registers; a backspace adds a
// blanking write state, an in-range read a wait for the read data, and a put that
// scrolls the blanking of the new bottom row a cell a cycle. The back end, through the
// single write port of the screen store, sets the rate: it takes no new command until
// it is back in idle. Scrolling moves a row offset, not the stored text.
module text_console_writer_top import cnsl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire in_item_t           item,
	output logic                    done,
	output out_item_t               result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [7:0] text_attr_q;
	logic       accept;
	logic       front_busy;
	logic       clearing;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	cmd_t       front_cmd;
	cmd_t       q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTR) begin
			text_attr_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, text_attr_q} : 32'd0;
	assign pready = 1'b1;

	assign busy = front_busy || clearing;
	assign accept = start && !busy;

	cnsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.q_full    (q_full),
		.push      (push),
		.cmd       (front_cmd),
		.front_busy(front_busy)
	);

	cnsl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(front_cmd),
		.pop     (pop),
		.head    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	cnsl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_attr(text_attr_q),
		.q_head   (q_head),
		.q_empty  (q_empty),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

// File: tb/sv/text_console_writer_top_test.sv
// Self-checking testbench of the text console writer: puts, reads, scrolls and attribute writes.
`timescale 1ns / 1ps

module text_console_writer_top_test;
	import cnsl_pkg::*;

	localparam logic MODE_PUT = 1'b0;
	localparam logic MODE_READ = 1'b1;
	localparam logic [PADDR_W-1:0] ADDR_TEXT_ATTR = PADDR_W'(4 * REG_TEXT_ATTR);
	localparam int MAX_INDEX = 2 ** IDX_W - 1;
	localparam int SETTLE_CYCLES = COLUMNS + 20;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int RANDOM_ITEMS = 530;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	in_item_t           item = '0;
	logic               done;
	out_item_t          result;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	logic [7:0] scr_glyph [CELLS];
	logic [7:0] scr_attr [CELLS];
	int         cur_pos;
	logic [7:0] cur_attr;

	out_item_t pending_results [$];
	out_item_t want;
	int        mismatch_count = 0;
	int        quiet_cycles = 0;
	int        burst_left = 0;

	text_console_writer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	function automatic logic screen_scroll();
		if (cur_pos < CELLS) return 1'b0;
		for (int i = 0; i < CELLS - COLUMNS; i++) begin
			scr_glyph[i] = scr_glyph[i + COLUMNS];
			scr_attr[i] = scr_attr[i + COLUMNS];
		end
		for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
			scr_glyph[i] = CH_SPACE;
			scr_attr[i] = cur_attr;
		end
		cur_pos = CELLS - COLUMNS;
		return 1'b1;
	endfunction

	function automatic out_item_t console_apply(input in_item_t it);
		out_item_t r;
		r = '0;
		if (it.mode == MODE_READ) begin
			if (it.cell_index < CELLS) begin
				r.read_glyph = scr_glyph[it.cell_index];
				r.read_attribute = scr_attr[it.cell_index];
			end
		end else if (it.char_code == CH_NEWLINE) begin
			cur_pos = (cur_pos / COLUMNS + 1) * COLUMNS;
			r.did_scroll = screen_scroll();
		end else if (it.char_code == CH_BACKSPACE) begin
			if (cur_pos > 0) begin
				cur_pos--;
				scr_glyph[cur_pos] = CH_SPACE;
				scr_attr[cur_pos] = cur_attr;
			end
		end else begin
			scr_glyph[cur_pos] = it.char_code;
			scr_attr[cur_pos] = cur_attr;
			cur_pos++;
			r.did_scroll = screen_scroll();
		end
		r.cursor_position = IDX_W'(cur_pos);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(15, 40);
			return 0;
		end
		if (r < 35) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.mode = MODE_PUT;
		it.char_code = 8'($urandom_range(0, 255));
		it.cell_index = IDX_W'($urandom_range(0, MAX_INDEX));
		if (r < 6) begin
			it.mode = MODE_READ;
			it.cell_index = IDX_W'(cur_pos > 0 ? cur_pos - 1 : 0);
		end else if (r < 16) begin
			it.mode = MODE_READ;
			it.cell_index = IDX_W'($urandom_range(0, CELLS - 1));
		end else if (r < 19) begin
			it.mode = MODE_READ;
			it.cell_index = IDX_W'($urandom_range(CELLS, MAX_INDEX));
		end else if (r < 34) begin
			it.char_code = CH_NEWLINE;
		end else if (r < 44) begin
			it.char_code = CH_BACKSPACE;
		end
		return it;
	endfunction

	task automatic check_field(input string what, input logic [IDX_W-1:0] exp_v,
			input logic [IDX_W-1:0] got_v);
		if (got_v !== exp_v) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
		end
	endtask

	task automatic send_item(input in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pending_results.push_back(console_apply(it));
	endtask

	task automatic put_char(input logic [7:0] ch);
		in_item_t it;
		it.mode = MODE_PUT;
		it.char_code = ch;
		it.cell_index = IDX_W'($urandom_range(0, MAX_INDEX));
		send_item(it);
	endtask

	task automatic read_cell(input int idx);
		in_item_t it;
		it.mode = MODE_READ;
		it.char_code = 8'($urandom_range(0, 255));
		it.cell_index = IDX_W'(idx);
		send_item(it);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic wait_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_text_attr(input logic [7:0] v);
		logic [31:0] rd;
		wait_idle();
		apb_access(1'b1, ADDR_TEXT_ATTR, {24'd0, v}, rd);
		cur_attr = v;
		apb_access(1'b0, ADDR_TEXT_ATTR, 32'd0, rd);
		check_field("text_attr readback", IDX_W'(v), IDX_W'(rd[7:0]));
	endtask

	task automatic test_reset_contents();
		read_cell(0);
		read_cell(CELLS - 1);
		read_cell(CELLS);
		read_cell(MAX_INDEX);
		put_char(CH_BACKSPACE);
	endtask

	task automatic test_each_command();
		in_item_t it;
		write_text_attr(8'hFF);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(8'h41);
		put_char(CH_BACKSPACE);
		put_char(CH_NEWLINE);
		put_char(8'h7E);
		write_text_attr(8'h00);
		put_char(CH_BACKSPACE);
		put_char(CH_BACKSPACE);
		put_char(8'h20);
		read_cell(0);
		read_cell(1);
		read_cell(2);
		read_cell(COLUMNS - 1);
		read_cell(COLUMNS);
		it.mode = MODE_READ;
		it.char_code = CH_NEWLINE;
		it.cell_index = IDX_W'(COLUMNS);
		send_item(it);
	endtask

	task automatic test_scroll();
		logic [7:0] ch;
		write_text_attr(8'($urandom_range(1, 254)));
		while (cur_pos < CELLS - COLUMNS) put_char(CH_NEWLINE);
		put_char(CH_NEWLINE);
		repeat (COLUMNS) begin
			ch = 8'($urandom_range(0, 255));
			if (ch == CH_NEWLINE || ch == CH_BACKSPACE) ch = CH_SPACE;
			put_char(ch);
		end
		repeat (6) read_cell($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 130 == 129) begin
				case (i / 130)
					0: write_text_attr(8'hFF);
					1: write_text_attr(8'h00);
					default: write_text_attr(8'($urandom_range(0, 255)));
				endcase
			end
			if (i == n / 2 + 7) drain_results();
			send_item(rand_item());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with nothing pending: cursor %0d", result.cursor_position);
			end else begin
				want = pending_results.pop_front();
				check_field("cursor_position", want.cursor_position, result.cursor_position);
				check_field("read_glyph", IDX_W'(want.read_glyph),
					IDX_W'(result.read_glyph));
				check_field("read_attribute", IDX_W'(want.read_attribute),
					IDX_W'(result.read_attribute));
				check_field("did_scroll", IDX_W'(want.did_scroll),
					IDX_W'(result.did_scroll));
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			scr_glyph[i] = CH_SPACE;
			scr_attr[i] = ATTR_RESET;
		end
		cur_pos = 0;
		cur_attr = ATTR_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_contents();
		test_each_command();
		test_scroll();
		test_random(RANDOM_ITEMS);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/cnsl_pkg.sv
rtl/core/cnsl_ram.sv
rtl/core/cnsl_front.sv
rtl/core/cnsl_queue.sv
rtl/core/cnsl_back.sv
rtl/core/text_console_writer_top.sv
tb/sv/text_console_writer_top_test.sv
